// ===== hdl/scq_pkg.sv =====
// Shared constants, types and translation tables for the scan code queue.
package scq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Set-1 modifier codes
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_CAPS_BREAK   = 8'hBA;
  localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;

  // Table length; make codes at or past this translate to zero
  localparam int TAB_LEN = 84;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic       caps;
  } cmd_t;

  typedef logic [7:0] tab_t [0:TAB_LEN-1];

  localparam tab_t TAB_PLAIN = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h0D, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h80, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h2F, 8'h8C, 8'h80, 8'h86, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h30, 8'hB1
  };

  localparam tab_t TAB_SHIFT = '{
    8'h00, 8'h21, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h0D, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0F, 8'h80, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h2A, 8'h7E, 8'h80, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h37,
    8'h38, 8'h39, 8'h80, 8'h34, 8'h35, 8'h36, 8'h80, 8'h31,
    8'h32, 8'h33, 8'h30, 8'hB1
  };

  localparam tab_t TAB_CAPS = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h0D, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0A, 8'h80, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h2F, 8'h8C, 8'h80, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h30, 8'hB1
  };

  localparam tab_t TAB_CAPS_SHIFT = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h0D, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0D, 8'h80, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
    8'h2A, 8'h7E, 8'h80, 8'h86, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h37,
    8'h38, 8'h39, 8'h80, 8'h34, 8'h35, 8'h36, 8'h80, 8'h31,
    8'h32, 8'h33, 8'h30, 8'hB1
  };

  // Make code (below 0x80) to character, table chosen by shift and caps
  function automatic logic [7:0] translate(input logic shift, input logic caps,
                                           input logic [7:0] code);
    logic [6:0] idx;
    logic [7:0] ch;
    idx = code[6:0];
    if (code >= 8'(TAB_LEN)) begin
      ch = 8'h00;
    end else if (shift) begin
      ch = caps ? TAB_CAPS_SHIFT[idx] : TAB_SHIFT[idx];
    end else begin
      ch = caps ? TAB_CAPS[idx] : TAB_PLAIN[idx];
    end
    return ch;
  endfunction

endpackage

// ===== hdl/scq_if.sv =====
// Channel interfaces: incoming request items and outgoing result items.
interface scq_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] scan_code;

  modport source (output valid, func, scan_code, input ready);
  modport sink (input valid, func, scan_code, output ready);
endinterface

interface scq_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;
  logic       queue_empty;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;
  logic       caps_on;
  logic       dropped;

  modport source (output valid, char_valid, char_code, queue_empty, shift_held,
                  ctrl_held, alt_held, caps_on, dropped, input ready);
  modport sink (input valid, char_valid, char_code, queue_empty, shift_held,
                ctrl_held, alt_held, caps_on, dropped, output ready);
endinterface

// ===== hdl/scq_front.sv =====
// Front end: modifier tracking, scan code classification and translation.
module scq_front (
  input  logic         clk,
  input  logic         rst,
  scq_in_if.sink       req,
  output logic         push,
  output scq_pkg::cmd_t push_cmd,
  input  logic         push_ready
);

  logic shift_flag, ctrl_flag, alt_flag, caps_flag, caps_released;
  logic shift_next, ctrl_next, alt_next, caps_next, released_next;
  logic is_mod;
  logic accept;

  assign req.ready = push_ready;
  assign accept    = req.valid && push_ready;
  assign push      = accept;

  always_comb begin
    shift_next    = shift_flag;
    ctrl_next     = ctrl_flag;
    alt_next      = alt_flag;
    caps_next     = caps_flag;
    released_next = caps_released;
    is_mod        = 1'b1;
    case (req.scan_code)
      scq_pkg::SC_RSHIFT_MAKE, scq_pkg::SC_LSHIFT_MAKE:   shift_next = 1'b1;
      scq_pkg::SC_RSHIFT_BREAK, scq_pkg::SC_LSHIFT_BREAK: shift_next = 1'b0;
      scq_pkg::SC_CTRL_MAKE:  ctrl_next = 1'b1;
      scq_pkg::SC_CTRL_BREAK: ctrl_next = 1'b0;
      scq_pkg::SC_ALT_MAKE:   alt_next = 1'b1;
      scq_pkg::SC_ALT_BREAK:  alt_next = 1'b0;
      scq_pkg::SC_CAPS_MAKE: begin
        // toggle only once per press/release cycle
        if (caps_released) begin
          caps_next     = ~caps_flag;
          released_next = 1'b0;
        end
      end
      scq_pkg::SC_CAPS_BREAK: released_next = 1'b1;
      scq_pkg::SC_EXT_PREFIX: is_mod = 1'b1;
      default: is_mod = 1'b0;
    endcase
    // read requests leave modifiers untouched
    if (req.func) begin
      shift_next    = shift_flag;
      ctrl_next     = ctrl_flag;
      alt_next      = alt_flag;
      caps_next     = caps_flag;
      released_next = caps_released;
    end
  end

  always_comb begin
    push_cmd.ch    = scq_pkg::translate(shift_next, caps_next, req.scan_code);
    push_cmd.shift = shift_next;
    push_cmd.ctrl  = ctrl_next;
    push_cmd.alt   = alt_next;
    push_cmd.caps  = caps_next;
    if (req.func) begin
      push_cmd.op = scq_pkg::CMD_READ;
    end else if (!is_mod && !req.scan_code[7]) begin
      push_cmd.op = scq_pkg::CMD_PUSH;
    end else begin
      push_cmd.op = scq_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag    <= 1'b0;
      ctrl_flag     <= 1'b0;
      alt_flag      <= 1'b0;
      caps_flag     <= 1'b0;
      caps_released <= 1'b1;
    end else if (accept) begin
      shift_flag    <= shift_next;
      ctrl_flag     <= ctrl_next;
      alt_flag      <= alt_next;
      caps_flag     <= caps_next;
      caps_released <= released_next;
    end
  end

endmodule

// ===== hdl/scq_cmd_fifo.sv =====
// Two-entry command queue between front and back ends.
module scq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scq_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output scq_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  scq_pkg::cmd_t slots [0:1];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[head];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        tail <= ~tail;
      end
      if (do_pop) begin
        head <= ~head;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/scq_back.sv =====
// Back end: character ring buffer and result register.
module scq_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  scq_pkg::cmd_t pop_cmd,
  output logic          pop,
  scq_out_if.source     rsp
);

  logic [7:0] char_store [0:scq_pkg::QUEUE_DEPTH-1];

  logic [scq_pkg::PTR_W-1:0] write_pointer, read_pointer;
  logic [scq_pkg::CNT_W-1:0] fill_count, fill_next;
  logic [7:0] rd_data;
  logic       wr_en, rd_en, drop, queue_full, queue_none;

  // result register
  logic out_valid, out_char_valid, out_empty, out_dropped;
  logic out_shift, out_ctrl, out_alt, out_caps;

  assign pop        = pop_valid && (!out_valid || rsp.ready);
  assign queue_full = (fill_count == scq_pkg::CNT_W'(scq_pkg::QUEUE_DEPTH));
  assign queue_none = (fill_count == '0);
  assign wr_en      = pop && (pop_cmd.op == scq_pkg::CMD_PUSH) && !queue_full;
  assign drop       = pop && (pop_cmd.op == scq_pkg::CMD_PUSH) && queue_full;
  assign rd_en      = pop && (pop_cmd.op == scq_pkg::CMD_READ) && !queue_none;

  always_comb begin
    fill_next = fill_count;
    if (wr_en) begin
      fill_next = fill_count + 1'b1;
    end else if (rd_en) begin
      fill_next = fill_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_store[write_pointer] <= pop_cmd.ch;
    end
  end

  // read data held until the next read so a stalled result keeps its character
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= char_store[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_count    <= '0;
    end else begin
      if (wr_en) begin
        write_pointer <= (write_pointer == scq_pkg::PTR_W'(scq_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : write_pointer + 1'b1;
      end
      if (rd_en) begin
        read_pointer <= (read_pointer == scq_pkg::PTR_W'(scq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : read_pointer + 1'b1;
      end
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_char_valid <= rd_en;
      out_empty      <= (fill_next == '0);
      out_dropped    <= drop;
      out_shift      <= pop_cmd.shift;
      out_ctrl       <= pop_cmd.ctrl;
      out_alt        <= pop_cmd.alt;
      out_caps       <= pop_cmd.caps;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.char_valid  = out_char_valid;
  assign rsp.char_code   = out_char_valid ? rd_data : 8'h00;
  assign rsp.queue_empty = out_empty;
  assign rsp.shift_held  = out_shift;
  assign rsp.ctrl_held   = out_ctrl;
  assign rsp.alt_held    = out_alt;
  assign rsp.caps_on     = out_caps;
  assign rsp.dropped     = out_dropped;

endmodule

// ===== hdl/scancode_to_ascii_queue.sv =====
// Top level: set-1 scan code translator with a character queue.
//
//  channel | dir | payload                                      | accepted when
//  --------+-----+----------------------------------------------+--------------
//  req     | in  | func, scan_code                              | valid & ready
//  rsp     | out | char_valid, char_code, queue_empty,          | valid & ready
//          |     | shift_held, ctrl_held, alt_held, caps_on,    |
//          |     | dropped                                      |
//
// One item per cycle sustained while rsp is ready. The command queue captures
// an item at the edge that accepts it; the back end executes it when it pops
// it from the queue and registers the result together with the ring buffer
// read, which raises rsp.valid.
// rst is synchronous: modifiers clear, caps release flag sets, queue empties.
// The buffer itself is not cleared; only written entries are ever read.
// A stalled rsp fills the two-entry command queue, then req.ready drops.
module scancode_to_ascii_queue (
  input  logic      clk,
  input  logic      rst,
  scq_in_if.sink    req,
  scq_out_if.source rsp
);

  logic          push, push_ready;
  scq_pkg::cmd_t push_cmd;
  logic          pop_valid, pop;
  scq_pkg::cmd_t pop_cmd;

  // classify scan codes, track modifiers, translate make codes
  scq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // decouples the front from result back-pressure
  scq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // ring buffer push/pop and result register
  scq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
